>>> rtl/core/gcr_fmt_pkg.sv
// Shared types, constants and code tables of the GCR sector formatter.
`default_nettype none

package gcr_fmt_pkg;

    localparam int SECTOR_BYTES = 256;
    localparam int POS_W        = $clog2(SECTOR_BYTES);
    localparam int TRACK_W      = 6;
    localparam int SECTOR_W     = 5;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int STEP_W       = 6;
    localparam int CNT_W        = 5;
    localparam int ACC_W        = 18;
    localparam int TOK_W        = 10;
    localparam int SHIFT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_ID_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_ID_SECOND = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] GAP_BYTE  = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_MARK  = 8'h08;
    localparam logic [BYTE_W-1:0] DATA_MARK = 8'h07;
    localparam logic [BYTE_W-1:0] HDR_FILL  = 8'h0F;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    // Token sequence of one sector
    localparam logic [STEP_W-1:0] STEP_SYNC1 = 6'd0;
    localparam logic [STEP_W-1:0] STEP_HDR   = 6'd5;
    localparam logic [STEP_W-1:0] STEP_GAP   = 6'd13;
    localparam logic [STEP_W-1:0] STEP_SYNC2 = 6'd22;
    localparam logic [STEP_W-1:0] STEP_MARK  = 6'd27;
    localparam logic [STEP_W-1:0] STEP_DATA  = 6'd28;
    localparam logic [STEP_W-1:0] STEP_CSUM  = 6'd29;
    localparam logic [STEP_W-1:0] STEP_PAD   = 6'd32;
    localparam logic [STEP_W-1:0] STEP_TAIL  = 6'd33;
    localparam logic [STEP_W-1:0] STEP_END   = 6'd38;

    typedef enum logic [1:0] {
        TOK_RAW,
        TOK_CODED,
        TOK_PAD
    } tok_kind_t;

    typedef struct packed {
        logic                first;
        logic                last;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [BYTE_W-1:0]   id_first;
        logic [BYTE_W-1:0]   id_second;
        logic [BYTE_W-1:0]   data;
        logic [BYTE_W-1:0]   csum;
    } cmd_t;

    typedef struct packed {
        tok_kind_t         kind;
        logic [BYTE_W-1:0] value;
        logic              end_mark;
    } token_t;

    function automatic logic [4:0] nyb_code(input logic [3:0] nyb);
        logic [4:0] code;
        unique case (nyb)
            4'h0: code = 5'h0A;
            4'h1: code = 5'h0B;
            4'h2: code = 5'h12;
            4'h3: code = 5'h13;
            4'h4: code = 5'h0E;
            4'h5: code = 5'h0F;
            4'h6: code = 5'h16;
            4'h7: code = 5'h17;
            4'h8: code = 5'h09;
            4'h9: code = 5'h19;
            4'hA: code = 5'h1A;
            4'hB: code = 5'h1B;
            4'hC: code = 5'h0D;
            4'hD: code = 5'h1D;
            4'hE: code = 5'h1E;
            4'hF: code = 5'h15;
            default: code = 5'h00;
        endcase
        return code;
    endfunction

    function automatic logic [TOK_W-1:0] gcr_code(input logic [BYTE_W-1:0] b);
        return {nyb_code(b[7:4]), nyb_code(b[3:0])};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/gcr_fmt_front.sv
// Front end: accepts data beats, tracks sector position and checksum, issues commands.
`default_nettype none

module gcr_fmt_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [gcr_fmt_pkg::TRACK_W-1:0]    s_track_number,
    input  wire logic [gcr_fmt_pkg::SECTOR_W-1:0]   s_sector_number,
    input  wire logic [gcr_fmt_pkg::BYTE_W-1:0]     s_data_byte,
    input  wire logic                               cfg_wr_en,
    input  wire logic [gcr_fmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcr_fmt_pkg::BYTE_W-1:0]     cfg_data,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output gcr_fmt_pkg::cmd_t                       q_cmd
);

    logic [gcr_fmt_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [gcr_fmt_pkg::BYTE_W-1:0] xor_reg;
    logic [gcr_fmt_pkg::BYTE_W-1:0] id_first_reg, id_second_reg;
    logic                           first, last;
    logic [gcr_fmt_pkg::BYTE_W-1:0] csum;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign first = (pos_reg == '0);
    assign last  = (pos_reg == gcr_fmt_pkg::POS_W'(gcr_fmt_pkg::SECTOR_BYTES - 1));
    assign csum  = (first ? gcr_fmt_pkg::ZERO_BYTE : xor_reg) ^ s_data_byte;
    assign pos_next = last ? '0 : pos_reg + 1'b1;

    always_comb begin
        q_cmd.first     = first;
        q_cmd.last      = last;
        q_cmd.track     = s_track_number;
        q_cmd.sector    = s_sector_number;
        q_cmd.id_first  = id_first_reg;
        q_cmd.id_second = id_second_reg;
        q_cmd.data      = s_data_byte;
        q_cmd.csum      = csum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (q_push) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            xor_reg <= csum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_first_reg  <= '0;
            id_second_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gcr_fmt_pkg::CFG_DISK_ID_FIRST:  id_first_reg  <= cfg_data;
                gcr_fmt_pkg::CFG_DISK_ID_SECOND: id_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gcr_fmt_queue.sv
// Two-entry command queue between front and back end.
`default_nettype none

module gcr_fmt_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire gcr_fmt_pkg::cmd_t  push_cmd,
    output logic                    full,
    input  wire logic               pop,
    output gcr_fmt_pkg::cmd_t       head_cmd,
    output logic                    head_valid
);

    gcr_fmt_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gcr_fmt_back.sv
// Back end: steps through the sector token sequence, packs bits, drives result beats.
`default_nettype none

module gcr_fmt_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire gcr_fmt_pkg::cmd_t               cmd,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_pop,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [gcr_fmt_pkg::BYTE_W-1:0]       m_gcr_byte,
    output logic                                 m_sector_end
);

    logic [gcr_fmt_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                            busy_reg, busy_next;
    logic [gcr_fmt_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [gcr_fmt_pkg::CNT_W-1:0]   cnt_reg, cnt_next, cnt_drained;
    logic                            end_flag_reg;
    logic                            m_valid_reg;
    logic [gcr_fmt_pkg::BYTE_W-1:0]  m_gcr_byte_reg;
    logic                            m_sector_end_reg;

    logic [gcr_fmt_pkg::STEP_W-1:0]  cur_step, end_step;
    logic [2:0]                      hdr_idx;
    logic [gcr_fmt_pkg::BYTE_W-1:0]  hdr_byte, hdr_csum;
    gcr_fmt_pkg::token_t             tok;
    logic                            drain, tok_take;
    logic [gcr_fmt_pkg::SHIFT_W-1:0] tok_width;
    logic [gcr_fmt_pkg::TOK_W-1:0]   tok_bits;
    logic [gcr_fmt_pkg::ACC_W-1:0]   acc_aligned;

    assign cur_step = busy_reg ? step_reg
                    : (cmd.first ? gcr_fmt_pkg::STEP_SYNC1 : gcr_fmt_pkg::STEP_DATA);
    assign end_step = cmd.last ? gcr_fmt_pkg::STEP_END : gcr_fmt_pkg::STEP_DATA;
    assign hdr_idx  = 3'(cur_step - gcr_fmt_pkg::STEP_HDR);
    assign hdr_csum = {3'b000, cmd.sector} ^ {2'b00, cmd.track} ^ cmd.id_second ^ cmd.id_first;

    always_comb begin
        unique case (hdr_idx)
            3'd0:    hdr_byte = gcr_fmt_pkg::HDR_MARK;
            3'd1:    hdr_byte = hdr_csum;
            3'd2:    hdr_byte = {3'b000, cmd.sector};
            3'd3:    hdr_byte = {2'b00, cmd.track};
            3'd4:    hdr_byte = cmd.id_second;
            3'd5:    hdr_byte = cmd.id_first;
            default: hdr_byte = gcr_fmt_pkg::HDR_FILL;
        endcase
    end

    always_comb begin
        tok.end_mark = 1'b0;
        priority if (cur_step < gcr_fmt_pkg::STEP_HDR) begin
            tok.kind  = gcr_fmt_pkg::TOK_RAW;
            tok.value = gcr_fmt_pkg::SYNC_BYTE;
        end else if (cur_step < gcr_fmt_pkg::STEP_GAP) begin
            tok.kind  = gcr_fmt_pkg::TOK_CODED;
            tok.value = hdr_byte;
        end else if (cur_step < gcr_fmt_pkg::STEP_SYNC2) begin
            tok.kind  = gcr_fmt_pkg::TOK_RAW;
            tok.value = gcr_fmt_pkg::GAP_BYTE;
        end else if (cur_step < gcr_fmt_pkg::STEP_MARK) begin
            tok.kind  = gcr_fmt_pkg::TOK_RAW;
            tok.value = gcr_fmt_pkg::SYNC_BYTE;
        end else if (cur_step == gcr_fmt_pkg::STEP_MARK) begin
            tok.kind  = gcr_fmt_pkg::TOK_CODED;
            tok.value = gcr_fmt_pkg::DATA_MARK;
        end else if (cur_step == gcr_fmt_pkg::STEP_DATA) begin
            tok.kind  = gcr_fmt_pkg::TOK_CODED;
            tok.value = cmd.data;
        end else if (cur_step == gcr_fmt_pkg::STEP_CSUM) begin
            tok.kind  = gcr_fmt_pkg::TOK_CODED;
            tok.value = cmd.csum;
        end else if (cur_step < gcr_fmt_pkg::STEP_PAD) begin
            tok.kind  = gcr_fmt_pkg::TOK_CODED;
            tok.value = gcr_fmt_pkg::ZERO_BYTE;
        end else if (cur_step == gcr_fmt_pkg::STEP_PAD) begin
            tok.kind  = gcr_fmt_pkg::TOK_PAD;
            tok.value = gcr_fmt_pkg::ZERO_BYTE;
        end else begin
            tok.kind     = gcr_fmt_pkg::TOK_RAW;
            tok.value    = gcr_fmt_pkg::GAP_BYTE;
            tok.end_mark = (cur_step == gcr_fmt_pkg::STEP_END);
        end
    end

    always_comb begin
        unique case (tok.kind)
            gcr_fmt_pkg::TOK_RAW: begin
                tok_width = 4'd8;
                tok_bits  = {2'b00, tok.value};
            end
            gcr_fmt_pkg::TOK_CODED: begin
                tok_width = 4'd10;
                tok_bits  = gcr_fmt_pkg::gcr_code(tok.value);
            end
            default: begin
                tok_width = (cnt_drained == '0) ? 4'd0 : 4'(5'd8 - cnt_drained);
                tok_bits  = '0;
            end
        endcase
    end

    assign drain       = (cnt_reg >= 5'd8) && (!m_valid_reg || m_ready);
    assign cnt_drained = drain ? cnt_reg - 5'd8 : cnt_reg;
    assign tok_take    = cmd_valid && (cnt_drained < 5'd8);
    assign cmd_pop     = tok_take && (cur_step == end_step);
    assign acc_aligned = acc_reg >> (cnt_reg - 5'd8);

    always_comb begin
        acc_next  = acc_reg;
        cnt_next  = cnt_drained;
        step_next = step_reg;
        busy_next = busy_reg;
        if (tok_take) begin
            acc_next  = (acc_reg << tok_width) | {8'h00, tok_bits};
            cnt_next  = cnt_drained + {1'b0, tok_width};
            step_next = cur_step + 1'b1;
            busy_next = !cmd_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            end_flag_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (tok_take && tok.end_mark) begin
                end_flag_reg <= 1'b1;
            end else if (drain) begin
                end_flag_reg <= 1'b0;
            end
            if (drain) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (drain) begin
            m_gcr_byte_reg   <= acc_aligned[7:0];
            m_sector_end_reg <= end_flag_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_gcr_byte   = m_gcr_byte_reg;
    assign m_sector_end = m_sector_end_reg;

endmodule

`default_nettype wire

>>> rtl/core/gcr_sector_formatter_core.sv
// Top level of the GCR sector formatter: front end, command queue and back end.
//
// Input beats carry one raw data byte each; the first beat of a sector also
// supplies track and sector number, which start the preamble (sync, GCR
// header, gap, sync, data mark). Each data byte becomes ten coded bits; the
// last beat of a sector appends checksum, two zero bytes, zero padding to a
// byte boundary and six gap bytes, the final one flagged by m_sector_end.
// Disk ids come from the write-only config port and are sampled on the
// first beat of each sector.
// m_valid rises once the first input beat of a sector has passed the command
// queue entry, the bit packer count and the output register.
// Throughput: the back end produces one result beat per cycle while the
// receiver is ready; a full sector is 360 result beats for 256 input beats,
// so the output port sets the sustained input rate, with a single input
// beat taken per cycle while the two-entry command queue has room.
// Reset clears position, queue, packer count and both disk ids (the checksum is not reset).
// A stalled receiver holds the output register; the packer then stops
// taking tokens and the queue fills until s_ready drops.
`default_nettype none

module gcr_sector_formatter_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [gcr_fmt_pkg::TRACK_W-1:0]    s_track_number,
    input  wire logic [gcr_fmt_pkg::SECTOR_W-1:0]   s_sector_number,
    input  wire logic [gcr_fmt_pkg::BYTE_W-1:0]     s_data_byte,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [gcr_fmt_pkg::BYTE_W-1:0]          m_gcr_byte,
    output logic                                    m_sector_end,
    input  wire logic                               cfg_wr_en,
    input  wire logic [gcr_fmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcr_fmt_pkg::BYTE_W-1:0]     cfg_data
);

    gcr_fmt_pkg::cmd_t push_cmd, head_cmd;
    logic              q_push, q_full, q_pop, head_valid;

    gcr_fmt_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_track_number  (s_track_number),
        .s_sector_number (s_sector_number),
        .s_data_byte     (s_data_byte),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (push_cmd)
    );

    gcr_fmt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    gcr_fmt_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (head_cmd),
        .cmd_valid    (head_valid),
        .cmd_pop      (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gcr_byte   (m_gcr_byte),
        .m_sector_end (m_sector_end)
    );

endmodule

`default_nettype wire

>>> sim/gcr_sector_formatter_core_tb.sv
// Testbench for the GCR sector formatter: random beats with idling, scoreboard against a predictor.
`timescale 1ns / 100ps

module gcr_sector_formatter_core_tb;

    localparam int HOLD_CYCLES = 300;

    localparam logic [4:0] GCR_TABLE [16] = '{
        5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
        5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
    };

    localparam logic [gcr_fmt_pkg::BYTE_W-1:0] DIRECTED [20] = '{
        8'h00, 8'hFF, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF,
        8'hFE, 8'hDC, 8'hBA, 8'h98, 8'h76, 8'h54, 8'h32, 8'h10, 8'h55, 8'hAA
    };

    typedef struct packed {
        logic [gcr_fmt_pkg::BYTE_W-1:0] gcr;
        logic                           last;
    } surface_beat_t;

    class gcr_scoreboard;
        logic [gcr_fmt_pkg::BYTE_W-1:0] id_first;
        logic [gcr_fmt_pkg::BYTE_W-1:0] id_second;
        int unsigned                    position;
        logic [gcr_fmt_pkg::BYTE_W-1:0] data_xor;
        logic [gcr_fmt_pkg::BYTE_W-1:0] spare_bits;
        int unsigned                    spare_count;
        surface_beat_t                  surface_q[$];
        int unsigned                    errors;

        function new();
            id_first    = '0;
            id_second   = '0;
            position    = 0;
            data_xor    = '0;
            spare_bits  = '0;
            spare_count = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [gcr_fmt_pkg::CFG_IDX_W-1:0] idx,
                                logic [gcr_fmt_pkg::BYTE_W-1:0] value);
            case (idx)
                gcr_fmt_pkg::CFG_DISK_ID_FIRST: id_first = value;
                gcr_fmt_pkg::CFG_DISK_ID_SECOND: id_second = value;
                default: ;
            endcase
        endfunction

        function void emit(logic [gcr_fmt_pkg::BYTE_W-1:0] b, logic last);
            surface_beat_t e;
            e.gcr  = b;
            e.last = last;
            surface_q.push_back(e);
        endfunction

        function void append_bits(logic [9:0] value, int unsigned nbits);
            logic [17:0] acc;
            int unsigned cnt;
            acc = ({10'd0, spare_bits} << nbits) | ({8'd0, value} & ((18'd1 << nbits) - 18'd1));
            cnt = spare_count + nbits;
            while (cnt >= 8) begin
                emit(8'(acc >> (cnt - 8)), 1'b0);
                cnt -= 8;
            end
            spare_bits  = 8'(acc & ((18'd1 << cnt) - 18'd1));
            spare_count = cnt;
        endfunction

        function void append_coded(logic [gcr_fmt_pkg::BYTE_W-1:0] b);
            append_bits({GCR_TABLE[b[7:4]], GCR_TABLE[b[3:0]]}, 10);
        endfunction

        function void append_raw(logic [gcr_fmt_pkg::BYTE_W-1:0] b, int unsigned count);
            for (int unsigned i = 0; i < count; i++) begin
                append_bits({2'b00, b}, 8);
            end
        endfunction

        function void note_beat(logic [gcr_fmt_pkg::TRACK_W-1:0] track,
                                logic [gcr_fmt_pkg::SECTOR_W-1:0] sector,
                                logic [gcr_fmt_pkg::BYTE_W-1:0] data);
            logic [gcr_fmt_pkg::BYTE_W-1:0] hdr_sum;
            if (position == 0) begin
                data_xor    = '0;
                spare_bits  = '0;
                spare_count = 0;
                hdr_sum = {3'b000, sector} ^ {2'b00, track} ^ id_second ^ id_first;
                append_raw(gcr_fmt_pkg::SYNC_BYTE, 5);
                append_coded(gcr_fmt_pkg::HDR_MARK);
                append_coded(hdr_sum);
                append_coded({3'b000, sector});
                append_coded({2'b00, track});
                append_coded(id_second);
                append_coded(id_first);
                append_coded(gcr_fmt_pkg::HDR_FILL);
                append_coded(gcr_fmt_pkg::HDR_FILL);
                append_raw(gcr_fmt_pkg::GAP_BYTE, 9);
                append_raw(gcr_fmt_pkg::SYNC_BYTE, 5);
                append_coded(gcr_fmt_pkg::DATA_MARK);
            end
            append_coded(data);
            data_xor ^= data;
            if (position + 1 >= gcr_fmt_pkg::SECTOR_BYTES) begin
                append_coded(data_xor);
                append_coded(gcr_fmt_pkg::ZERO_BYTE);
                append_coded(gcr_fmt_pkg::ZERO_BYTE);
                // pad to a byte boundary
                if (spare_count != 0) append_bits(10'd0, 8 - spare_count);
                for (int i = 0; i < 6; i++) begin
                    emit(gcr_fmt_pkg::GAP_BYTE, i == 5);
                end
                position    = 0;
                data_xor    = '0;
                spare_bits  = '0;
                spare_count = 0;
            end else begin
                position++;
            end
        endfunction

        function void check_beat(logic [gcr_fmt_pkg::BYTE_W-1:0] gcr, logic last);
            surface_beat_t e;
            if (surface_q.size() == 0) begin
                $error("gcr_byte: no beat expected, actual %h (sector_end %b)", gcr, last);
                errors++;
            end else begin
                e = surface_q.pop_front();
                if (gcr !== e.gcr) begin
                    $error("gcr_byte: expected %h, actual %h", e.gcr, gcr);
                    errors++;
                end
                if (last !== e.last) begin
                    $error("sector_end: expected %b, actual %b", e.last, last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return surface_q.size();
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [gcr_fmt_pkg::TRACK_W-1:0]     s_track_number;
    logic [gcr_fmt_pkg::SECTOR_W-1:0]    s_sector_number;
    logic [gcr_fmt_pkg::BYTE_W-1:0]      s_data_byte;
    logic                                m_valid;
    logic                                m_ready;
    logic [gcr_fmt_pkg::BYTE_W-1:0]      m_gcr_byte;
    logic                                m_sector_end;
    logic                                cfg_wr_en;
    logic [gcr_fmt_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [gcr_fmt_pkg::BYTE_W-1:0]      cfg_data;

    gcr_scoreboard sb = new();

    int unsigned                      sender_idle_pct = 0;
    int unsigned                      recv_stall_pct  = 0;
    int unsigned                      hold_requests   = 0;
    int unsigned                      hold_served     = 0;
    int unsigned                      hold_left       = 0;
    int unsigned                      sector_beats    = 0;
    logic [gcr_fmt_pkg::TRACK_W-1:0]  hdr_track;
    logic [gcr_fmt_pkg::SECTOR_W-1:0] hdr_sector;

    gcr_sector_formatter_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_track_number  (s_track_number),
        .s_sector_number (s_sector_number),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_gcr_byte      (m_gcr_byte),
        .m_sector_end    (m_sector_end),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_ready     <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_beat(m_gcr_byte, m_sector_end);
    end

    task automatic send_beat(input logic [gcr_fmt_pkg::BYTE_W-1:0] data);
        logic [gcr_fmt_pkg::TRACK_W-1:0]  trk;
        logic [gcr_fmt_pkg::SECTOR_W-1:0] sec;
        if (sector_beats == 0) begin
            trk = hdr_track;
            sec = hdr_sector;
        end else begin
            trk = gcr_fmt_pkg::TRACK_W'($urandom_range(35, 1));
            sec = gcr_fmt_pkg::SECTOR_W'($urandom_range(20, 0));
        end
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid         <= 1'b1;
        s_track_number  <= trk;
        s_sector_number <= sec;
        s_data_byte     <= data;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(trk, sec, data);
        sector_beats = (sector_beats + 1) % gcr_fmt_pkg::SECTOR_BYTES;
    endtask

    task automatic run_beats(input int n, input int unsigned s_pct, input int unsigned r_pct);
        sender_idle_pct = s_pct;
        recv_stall_pct  = r_pct;
        repeat (n) send_beat(gcr_fmt_pkg::BYTE_W'($urandom_range(255)));
    endtask

    // hold the input until every expected beat is out
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_ids(input logic [gcr_fmt_pkg::BYTE_W-1:0] first,
                             input logic [gcr_fmt_pkg::BYTE_W-1:0] second);
        cfg_wr_en <= 1'b1;
        cfg_index <= gcr_fmt_pkg::CFG_DISK_ID_FIRST;
        cfg_data  <= first;
        @(posedge aclk);
        sb.write_reg(gcr_fmt_pkg::CFG_DISK_ID_FIRST, first);
        cfg_index <= gcr_fmt_pkg::CFG_DISK_ID_SECOND;
        cfg_data  <= second;
        @(posedge aclk);
        sb.write_reg(gcr_fmt_pkg::CFG_DISK_ID_SECOND, second);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_track_number  = '0;
        s_sector_number = '0;
        s_data_byte     = '0;
        m_ready         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = gcr_fmt_pkg::CFG_DISK_ID_FIRST;
        cfg_data        = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first sector: lowest track and sector, directed data up front
        write_ids(8'hFF, 8'h00);
        hdr_track  = 6'd1;
        hdr_sector = 5'd0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        for (int i = 0; i < 20; i++) send_beat(DIRECTED[i]);
        run_beats(56, 70, 0);
        run_beats(56, 0, 70);
        run_beats(56, 24, 24);
        hold_requests++;
        run_beats(68, 0, 0);
        drain();

        // second sector: highest track and sector; ids written mid-sector apply next time
        write_ids(8'h00, 8'hFF);
        hdr_track  = 6'd35;
        hdr_sector = 5'd20;
        run_beats(12, 24, 24);
        drain();
        write_ids(gcr_fmt_pkg::BYTE_W'($urandom_range(255)),
                  gcr_fmt_pkg::BYTE_W'($urandom_range(255)));
        run_beats(12, 0, 0);
        drain();

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> gcr_sector_formatter_core.f
rtl/core/gcr_fmt_pkg.sv
rtl/core/gcr_fmt_front.sv
rtl/core/gcr_fmt_queue.sv
rtl/core/gcr_fmt_back.sv
rtl/core/gcr_sector_formatter_core.sv
sim/gcr_sector_formatter_core_tb.sv
